[design/pur_pkg.sv]
// Shared types, constants and the nibble character table of the unmask and run decoder.
`timescale 1ns / 1ps
package pur_pkg;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = QPTR_W + 1;

   localparam logic [1:0] CSR_SESSION_MODE = 2'd0;
   localparam logic [1:0] CSR_SESSION_KEY  = 2'd1;

   localparam logic [2:0] MODE_SUB     = 3'd0;
   localparam logic [2:0] MODE_ADD     = 3'd1;
   localparam logic [2:0] MODE_SUB_XOR = 3'd2;
   localparam logic [2:0] MODE_ADD_XOR = 3'd3;

   localparam logic [7:0] KEY_OFFSET   = 8'h40;
   localparam logic [7:0] XOR_MASK     = 8'hC3;
   localparam logic [7:0] FIXED_OFFSET = 8'h0F;
   localparam logic [7:0] END_CODE     = 8'hFF;
   localparam logic [7:0] PLAIN_MASK   = 8'hFF;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_PLAIN  = 2'd1,
      PH_PACKED = 2'd2
   } phase_type;

   typedef struct packed {
      logic       two;
      logic       is_end;
      logic [7:0] c0;
      logic [7:0] c1;
   } pur_entry_type;

   function automatic logic [7:0] nibble_char(input logic [3:0] nib);
      logic [7:0] ch;
      case (nib)
         4'd1:    ch = 8'h20;
         4'd2:    ch = 8'h2D;
         4'd3:    ch = 8'h2E;
         4'd14:   ch = 8'h0A;
         4'd0:    ch = 8'h00;
         4'd15:   ch = 8'h00;
         default: ch = 8'h30 + {4'd0, nib - 4'd4};
      endcase
      return ch;
   endfunction

   function automatic logic nibble_ok(input logic [3:0] nib);
      return (nib != 4'd0) && (nib != 4'd15);
   endfunction

endpackage

[design/pur_front.sv]
// Front part: configuration registers, unmasking, run state and result classification.
`timescale 1ns / 1ps
module pur_front
   import pur_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [7:0]    req_in_byte,
   input  logic          csr_wr_en,
   input  logic [1:0]    csr_index,
   input  logic [7:0]    csr_wr_data,
   input  logic          q_full,
   output logic          q_push,
   output pur_entry_type q_entry
);

   logic [2:0] mode_ff;
   logic [7:0] key_ff;
   phase_type  phase_ff, phase_in;
   logic [6:0] rem_ff, rem_in;

   logic       accept;
   logic [7:0] key_eff;
   logic [7:0] u;
   logic [3:0] hi, lo;
   logic       hv, take_lo;
   logic [6:0] rem1, rem2;

   assign accept  = req_valid && !q_full;
   assign key_eff = key_ff + KEY_OFFSET;
   assign hi      = u[7:4];
   assign lo      = u[3:0];
   assign hv      = nibble_ok(hi);
   assign rem1    = hv ? rem_ff - 7'd1 : rem_ff;
   assign take_lo = nibble_ok(lo) && (rem1 != 7'd0);
   assign rem2    = take_lo ? rem1 - 7'd1 : rem1;

   always_comb begin
      case (mode_ff)
         MODE_SUB:     u = req_in_byte - key_eff;
         MODE_ADD:     u = req_in_byte + key_eff;
         MODE_SUB_XOR: u = (req_in_byte - key_eff) ^ XOR_MASK;
         MODE_ADD_XOR: u = (req_in_byte + key_eff) ^ XOR_MASK;
         default:      u = req_in_byte - FIXED_OFFSET;
      endcase
   end

   always_comb begin
      phase_in       = phase_ff;
      rem_in         = rem_ff;
      q_push         = 1'b0;
      q_entry.two    = 1'b0;
      q_entry.is_end = 1'b0;
      q_entry.c0     = 8'h00;
      q_entry.c1     = 8'h00;
      if (u == END_CODE) begin
         phase_in       = PH_HEADER;
         rem_in         = 7'd0;
         q_push         = accept;
         q_entry.is_end = 1'b1;
      end else if (phase_ff == PH_PLAIN && rem_ff != 7'd0) begin
         rem_in     = rem_ff - 7'd1;
         phase_in   = (rem_ff == 7'd1) ? PH_HEADER : PH_PLAIN;
         q_push     = accept;
         q_entry.c0 = u ^ PLAIN_MASK;
      end else if (phase_ff == PH_PACKED && rem_ff != 7'd0) begin
         rem_in      = rem2;
         phase_in    = (rem2 == 7'd0) ? PH_HEADER : PH_PACKED;
         q_push      = accept && (hv || take_lo);
         q_entry.two = hv && take_lo;
         q_entry.c0  = hv ? nibble_char(hi) : nibble_char(lo);
         q_entry.c1  = nibble_char(lo);
      end else if (u[6:0] == 7'd0) begin
         phase_in = PH_HEADER;
         rem_in   = 7'd0;
      end else begin
         phase_in = u[7] ? PH_PACKED : PH_PLAIN;
         rem_in   = u[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         rem_ff   <= 7'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         rem_ff   <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 3'd0;
         key_ff  <= 8'd0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SESSION_MODE: mode_ff <= csr_wr_data[2:0];
            CSR_SESSION_KEY:  key_ff  <= csr_wr_data;
            default:          ;
         endcase
      end
   end

endmodule

[design/pur_queue.sv]
// Short queue of classified requests between the front and back parts.
`timescale 1ns / 1ps
module pur_queue
   import pur_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  pur_entry_type push_entry,
   input  logic          pop,
   output pur_entry_type head,
   output logic          full,
   output logic          nonempty
);

   pur_entry_type           entries_ff [QDEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]       cnt_ff;
   logic                    do_push, do_pop;

   assign full     = (cnt_ff == QCNT_W'(QDEPTH));
   assign nonempty = (cnt_ff != '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && nonempty;
   assign head     = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   cnt_ff <= cnt_ff + 1'b1;
            2'b01:   cnt_ff <= cnt_ff - 1'b1;
            default: ;
         endcase
      end
   end

endmodule

[design/pur_back.sv]
// Back part: sends one or two results per queued request through an output register.
`timescale 1ns / 1ps
module pur_back
   import pur_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  pur_entry_type head,
   input  logic          nonempty,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [7:0]    rsp_out_char,
   output logic          rsp_packet_end,
   output logic          rsp_last
);

   logic       valid_ff, valid_in;
   logic       pend_ff, pend_in;
   logic [7:0] pend_char_ff;
   logic [7:0] char_ff, char_in;
   logic       end_ff, end_in;
   logic       last_ff, last_in;
   logic       out_free;

   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      pend_in  = pend_ff;
      char_in  = char_ff;
      end_in   = end_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (out_free) begin
         if (pend_ff) begin
            valid_in = 1'b1;
            pend_in  = 1'b0;
            char_in  = pend_char_ff;
            end_in   = 1'b0;
            last_in  = 1'b1;
         end else if (nonempty) begin
            pop      = 1'b1;
            valid_in = 1'b1;
            pend_in  = head.two;
            char_in  = head.c0;
            end_in   = head.is_end;
            last_in  = !head.two;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      end_ff  <= end_in;
      last_ff <= last_in;
      if (pop) begin
         pend_char_ff <= head.c1;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_char   = char_ff;
   assign rsp_packet_end = end_ff;
   assign rsp_last       = last_ff;

endmodule

[design/packet_unmask_run_decoder_core.sv]
// Top level of the packet unmask and run decoder.
// The decoder takes one masked byte per request and can accept a request every
// cycle while its four-entry request queue has room. Each byte gives zero, one or
// two results; the result channel carries one result per cycle unless stalled, so
// a packed-run byte that yields two characters sends them one after the other.
// With an empty queue and a free result channel, a result passes through the queue
// entry and then the output register before it is valid. Header bytes and bytes
// whose nibbles are both skipped give no result. The user writes session mode and
// key at index 0 and 1 only while the decoder is idle; the block does not check it.
`timescale 1ns / 1ps
module packet_unmask_run_decoder_core
   import pur_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_packet_end,
   output logic       rsp_last,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wr_data
);

   pur_entry_type push_entry, head;
   logic          push, pop, q_full, q_nonempty;

   assign req_stall = q_full;

   pur_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .q_push      (push),
      .q_entry     (push_entry)
   );

   pur_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (q_full),
      .nonempty   (q_nonempty)
   );

   pur_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .nonempty       (q_nonempty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_char   (rsp_out_char),
      .rsp_packet_end (rsp_packet_end),
      .rsp_last       (rsp_last)
   );

`ifndef ASSERT_OFF
   a_end_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_end |-> rsp_out_char == 8'h00 && rsp_last)
      else $error("End marker carries a character or is not last.");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Result valid right after reset.");

   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      q_full |-> q_nonempty)
      else $error("Request queue full and empty at once.");
`endif

endmodule
